### design/gpta_pkg.sv
`default_nettype none

package gpta_pkg;

   localparam int MAX_WORKERS = 16;
   localparam int WORKER_BITS = 4;
   localparam int CAP_BITS    = 8;
   localparam int VALUE_BITS  = 16;
   localparam int BENEFIT_BITS = 15;
   localparam int COUNT_BITS  = 9;
   localparam int INDEX_BITS  = 8;
   localparam int TOTAL_BITS  = 23;

   localparam logic [CAP_BITS-1:0]   CAP_MAX   = {CAP_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_BENEFIT = 1'b1;

   typedef struct packed {
      logic                          func;
      logic [WORKER_BITS-1:0]        worker;
      logic signed [VALUE_BITS-1:0]  value;
      logic                          last_worker;
      logic                          last_task;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   task_index;
      logic [WORKER_BITS-1:0]  chosen_worker;
      logic                    assigned;
      logic [BENEFIT_BITS-1:0] gained;
      logic                    job_done;
      logic [TOTAL_BITS-1:0]   job_total;
   } rsp_type;

endpackage

`default_nettype wire

### design/gpta_core.sv
`default_nettype none

module gpta_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire gpta_pkg::req_type item,
   output gpta_pkg::rsp_type      result,
   output logic                   result_valid
);

   logic [gpta_pkg::CAP_BITS-1:0]     cap_ff [gpta_pkg::MAX_WORKERS];
   logic                              best_valid_ff, best_valid_in;
   logic [gpta_pkg::WORKER_BITS-1:0]  best_worker_ff, best_worker_in;
   logic [gpta_pkg::BENEFIT_BITS-1:0] best_benefit_ff, best_benefit_in;
   logic [gpta_pkg::CAP_BITS-1:0]     best_cap_ff, best_cap_in;
   logic [gpta_pkg::COUNT_BITS-1:0]   task_count_ff, task_count_in;
   logic [gpta_pkg::COUNT_BITS-1:0]   assigned_count_ff, assigned_count_in;
   logic [gpta_pkg::TOTAL_BITS-1:0]   running_total_ff, running_total_in;

   logic                              is_load;
   logic                              end_task;
   logic                              value_pos;
   logic [gpta_pkg::CAP_BITS-1:0]     cap_w;
   logic [gpta_pkg::CAP_BITS-1:0]     clamped;
   logic                              take;
   logic                              cur_valid;
   logic [gpta_pkg::WORKER_BITS-1:0]  cur_worker;
   logic [gpta_pkg::BENEFIT_BITS-1:0] cur_benefit;
   logic [gpta_pkg::CAP_BITS-1:0]     cur_cap;
   logic [gpta_pkg::TOTAL_BITS:0]     total_sum;
   logic [gpta_pkg::TOTAL_BITS-1:0]   total_next;
   logic [gpta_pkg::COUNT_BITS-1:0]   assigned_next;
   logic [gpta_pkg::COUNT_BITS-1:0]   task_next;
   logic                              cap_we;
   logic [gpta_pkg::WORKER_BITS-1:0]  cap_waddr;
   logic [gpta_pkg::CAP_BITS-1:0]     cap_wdata;

   assign is_load   = (item.func == gpta_pkg::FUNC_LOAD);
   assign end_task  = !is_load && item.last_worker;
   assign value_pos = !item.value[gpta_pkg::VALUE_BITS-1] && (item.value != '0);
   assign cap_w     = cap_ff[item.worker];

   // Negative loads store zero; loads above the field range saturate.
   always_comb begin
      if (item.value[gpta_pkg::VALUE_BITS-1]) begin
         clamped = '0;
      end else if (item.value[gpta_pkg::BENEFIT_BITS-1:0] >
                   gpta_pkg::BENEFIT_BITS'(gpta_pkg::CAP_MAX)) begin
         clamped = gpta_pkg::CAP_MAX;
      end else begin
         clamped = item.value[gpta_pkg::CAP_BITS-1:0];
      end
   end

   // Strictly greater wins, so the earlier worker keeps a tie.
   assign take = !is_load && (cap_w != '0) && value_pos &&
                 (!best_valid_ff ||
                  (item.value[gpta_pkg::BENEFIT_BITS-1:0] > best_benefit_ff));

   assign cur_valid   = best_valid_ff || take;
   assign cur_worker  = take ? item.worker : best_worker_ff;
   assign cur_benefit = take ? item.value[gpta_pkg::BENEFIT_BITS-1:0] : best_benefit_ff;
   assign cur_cap     = take ? cap_w : best_cap_ff;

   assign total_sum = (gpta_pkg::TOTAL_BITS+1)'(running_total_ff) +
                      (gpta_pkg::TOTAL_BITS+1)'(cur_benefit);

   always_comb begin
      total_next    = running_total_ff;
      assigned_next = assigned_count_ff;
      if (cur_valid) begin
         total_next = total_sum[gpta_pkg::TOTAL_BITS] ? gpta_pkg::TOTAL_MAX :
                      total_sum[gpta_pkg::TOTAL_BITS-1:0];
         if (assigned_count_ff != gpta_pkg::COUNT_MAX) begin
            assigned_next = assigned_count_ff + 1'b1;
         end
      end
      task_next = (task_count_ff != gpta_pkg::COUNT_MAX) ?
                  task_count_ff + 1'b1 : task_count_ff;
   end

   // At most one table write per item: a load, or the decrement at the end of a task.
   always_comb begin
      cap_we    = 1'b0;
      cap_waddr = item.worker;
      cap_wdata = clamped;
      if (item_valid && is_load) begin
         cap_we = 1'b1;
      end else if (item_valid && end_task && cur_valid && (cur_cap != '0)) begin
         cap_we    = 1'b1;
         cap_waddr = cur_worker;
         cap_wdata = cur_cap - 1'b1;
      end
   end

   always_comb begin
      best_valid_in     = best_valid_ff;
      best_worker_in    = best_worker_ff;
      best_benefit_in   = best_benefit_ff;
      best_cap_in       = best_cap_ff;
      task_count_in     = task_count_ff;
      assigned_count_in = assigned_count_ff;
      running_total_in  = running_total_ff;
      if (item_valid) begin
         if (is_load) begin
            // The held capacity copy follows a reload of the current leader.
            if (best_valid_ff && (item.worker == best_worker_ff)) begin
               best_cap_in = clamped;
            end
         end else if (end_task) begin
            best_valid_in   = 1'b0;
            best_worker_in  = '0;
            best_benefit_in = '0;
            best_cap_in     = '0;
            if (item.last_task) begin
               task_count_in     = '0;
               assigned_count_in = '0;
               running_total_in  = '0;
            end else begin
               task_count_in     = task_next;
               assigned_count_in = assigned_next;
               running_total_in  = total_next;
            end
         end else begin
            best_valid_in   = cur_valid;
            best_worker_in  = cur_worker;
            best_benefit_in = cur_benefit;
            best_cap_in     = cur_cap;
         end
      end
   end

   always_comb begin
      result_valid         = end_task;
      result.task_index    = task_count_ff[gpta_pkg::INDEX_BITS-1:0];
      result.chosen_worker = cur_valid ? cur_worker : '0;
      result.assigned      = cur_valid;
      result.gained        = cur_valid ? cur_benefit : '0;
      result.job_done      = item.last_task;
      result.job_total     = (item.last_task && (assigned_next == task_next)) ?
                             total_next : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpta_pkg::MAX_WORKERS; i++) begin
            cap_ff[i] <= '0;
         end
         best_valid_ff     <= 1'b0;
         best_worker_ff    <= '0;
         best_benefit_ff   <= '0;
         best_cap_ff       <= '0;
         task_count_ff     <= '0;
         assigned_count_ff <= '0;
         running_total_ff  <= '0;
      end else begin
         if (cap_we) begin
            cap_ff[cap_waddr] <= cap_wdata;
         end
         best_valid_ff     <= best_valid_in;
         best_worker_ff    <= best_worker_in;
         best_benefit_ff   <= best_benefit_in;
         best_cap_ff       <= best_cap_in;
         task_count_ff     <= task_count_in;
         assigned_count_ff <= assigned_count_in;
         running_total_ff  <= running_total_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      best_valid_ff |-> (best_benefit_ff != '0))
      else $error("leader held with zero benefit");

   assert property (@(posedge clock) disable iff (reset)
      assigned_count_ff <= task_count_ff)
      else $error("more tasks assigned than decided");

   assert property (@(posedge clock) disable iff (reset)
      (running_total_ff != '0) |-> (assigned_count_ff != '0))
      else $error("total collected without any assignment");

   assert property (@(posedge clock) disable iff (reset)
      (item_valid && end_task) |=> !best_valid_ff)
      else $error("leader survived the end of its task");
`endif

endmodule

`default_nettype wire

### design/greedy_per_task_assignment.sv
// A result is formed from the entry that ends its task as that entry leaves the
// input register, and is held in the result register while rsp_valid is high.
// Throughput: one entry per cycle; while a result waits on rsp_stall the input
// register holds one more entry and then req_stall rises.
// Reset (synchronous) zeroes all worker capacities, the current leader and
// the job counters, and empties both registers.
`default_nettype none

module greedy_per_task_assignment (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_func,
   input  wire logic [gpta_pkg::WORKER_BITS-1:0]    req_worker,
   input  wire logic signed [gpta_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic                                req_last_worker,
   input  wire logic                                req_last_task,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [gpta_pkg::INDEX_BITS-1:0]          rsp_task_index,
   output logic [gpta_pkg::WORKER_BITS-1:0]         rsp_chosen_worker,
   output logic                                     rsp_assigned,
   output logic [gpta_pkg::BENEFIT_BITS-1:0]        rsp_gained,
   output logic                                     rsp_job_done,
   output logic [gpta_pkg::TOTAL_BITS-1:0]          rsp_job_total
);

   logic              in_valid_ff, in_valid_in;
   gpta_pkg::req_type in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   gpta_pkg::rsp_type rsp_item_ff;
   gpta_pkg::rsp_type core_result;
   logic              core_result_valid;
   logic              out_free;
   logic              advance;
   logic              req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_comb begin
      if (advance && core_result_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   gpta_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (advance),
      .item         (in_item_ff),
      .result       (core_result),
      .result_valid (core_result_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.func        <= req_func;
         in_item_ff.worker      <= req_worker;
         in_item_ff.value       <= req_value;
         in_item_ff.last_worker <= req_last_worker;
         in_item_ff.last_task   <= req_last_task;
      end
      if (advance && core_result_valid) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_index    = rsp_item_ff.task_index;
   assign rsp_chosen_worker = rsp_item_ff.chosen_worker;
   assign rsp_assigned      = rsp_item_ff.assigned;
   assign rsp_gained        = rsp_item_ff.gained;
   assign rsp_job_done      = rsp_item_ff.job_done;
   assign rsp_job_total     = rsp_item_ff.job_total;

endmodule

`default_nettype wire

### verif/tb_greedy_per_task_assignment.sv
`timescale 1ns / 100ps

module tb_greedy_per_task_assignment;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_CYCLES = 20;
   localparam int PEND_BITS    = 4;
   localparam int PEND_DEPTH   = 1 << PEND_BITS;

   typedef logic [gpta_pkg::WORKER_BITS-1:0]       worker_type;
   typedef logic signed [gpta_pkg::VALUE_BITS-1:0] value_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_func;
   logic [gpta_pkg::WORKER_BITS-1:0]      req_worker;
   logic signed [gpta_pkg::VALUE_BITS-1:0] req_value;
   logic                                  req_last_worker;
   logic                                  req_last_task;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [gpta_pkg::INDEX_BITS-1:0]       rsp_task_index;
   logic [gpta_pkg::WORKER_BITS-1:0]      rsp_chosen_worker;
   logic                                  rsp_assigned;
   logic [gpta_pkg::BENEFIT_BITS-1:0]     rsp_gained;
   logic                                  rsp_job_done;
   logic [gpta_pkg::TOTAL_BITS-1:0]       rsp_job_total;

   greedy_per_task_assignment dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_worker        (req_worker),
      .req_value         (req_value),
      .req_last_worker   (req_last_worker),
      .req_last_task     (req_last_task),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_task_index    (rsp_task_index),
      .rsp_chosen_worker (rsp_chosen_worker),
      .rsp_assigned      (rsp_assigned),
      .rsp_gained        (rsp_gained),
      .rsp_job_done      (rsp_job_done),
      .rsp_job_total     (rsp_job_total)
   );

   // Shadow copy of the assignment state.
   logic [gpta_pkg::CAP_BITS-1:0]     cap_left [gpta_pkg::MAX_WORKERS];
   logic                              lead_valid;
   logic [gpta_pkg::WORKER_BITS-1:0]  lead_worker;
   logic [gpta_pkg::BENEFIT_BITS-1:0] lead_benefit;
   logic [gpta_pkg::COUNT_BITS-1:0]   tasks_seen;
   logic [gpta_pkg::COUNT_BITS-1:0]   tasks_assigned;
   logic [gpta_pkg::TOTAL_BITS-1:0]   job_sum;

   // Expected results in order of their transfer.
   gpta_pkg::rsp_type      decision_fifo [PEND_DEPTH];
   logic [PEND_BITS-1:0]   wr_ptr;
   logic [PEND_BITS-1:0]   rd_ptr;
   int                     pend_count;
   gpta_pkg::rsp_type      want;
   int                     errors;
   int                     items_sent;
   int                     idle_cycles;
   bit                     req_quiet;
   bit                     rsp_quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait(input bit quiet);
      if (quiet) return 0;
      case ($urandom_range(0, 3))
         0, 1: return 0;
         2: return int'($urandom_range(1, 3));
         default: return int'($urandom_range(0, 17));
      endcase
   endfunction

   function automatic void predict_assignment(input gpta_pkg::req_type item);
      gpta_pkg::rsp_type               d;
      int                              v;
      logic [gpta_pkg::TOTAL_BITS:0]   sum;
      v = int'(item.value);
      if (item.func == gpta_pkg::FUNC_LOAD) begin
         if (v < 0)
            cap_left[item.worker] = '0;
         else if (v > int'(gpta_pkg::CAP_MAX))
            cap_left[item.worker] = gpta_pkg::CAP_MAX;
         else
            cap_left[item.worker] = v[gpta_pkg::CAP_BITS-1:0];
         return;
      end
      // Strictly larger wins, so on a tie the earlier entry keeps the task.
      if (cap_left[item.worker] != '0 && v > 0 &&
          (!lead_valid || v > int'(lead_benefit))) begin
         lead_valid   = 1'b1;
         lead_worker  = item.worker;
         lead_benefit = v[gpta_pkg::BENEFIT_BITS-1:0];
      end
      if (!item.last_worker) return;
      d = '0;
      d.task_index = tasks_seen[gpta_pkg::INDEX_BITS-1:0];
      if (lead_valid) begin
         d.chosen_worker = lead_worker;
         d.assigned      = 1'b1;
         d.gained        = lead_benefit;
         if (cap_left[lead_worker] != '0)
            cap_left[lead_worker] = cap_left[lead_worker] - 1'b1;
         sum = (gpta_pkg::TOTAL_BITS+1)'(job_sum) + (gpta_pkg::TOTAL_BITS+1)'(lead_benefit);
         job_sum = sum[gpta_pkg::TOTAL_BITS] ? gpta_pkg::TOTAL_MAX :
                   sum[gpta_pkg::TOTAL_BITS-1:0];
         if (tasks_assigned != gpta_pkg::COUNT_MAX)
            tasks_assigned = tasks_assigned + 1'b1;
      end
      if (tasks_seen != gpta_pkg::COUNT_MAX)
         tasks_seen = tasks_seen + 1'b1;
      lead_valid   = 1'b0;
      lead_worker  = '0;
      lead_benefit = '0;
      if (item.last_task) begin
         d.job_done  = 1'b1;
         d.job_total = (tasks_assigned == tasks_seen) ? job_sum : '0;
         tasks_seen     = '0;
         tasks_assigned = '0;
         job_sum        = '0;
      end
      if (pend_count == PEND_DEPTH) begin
         $display("%0t: result backlog full, expected at most %0d actual %0d",
                  $time, PEND_DEPTH, pend_count + 1);
         errors++;
      end else begin
         decision_fifo[wr_ptr] = d;
         wr_ptr = wr_ptr + 1'b1;
         pend_count++;
      end
   endfunction

   // Called in the step of a clock edge; returns in the step of the transfer.
   task automatic send_entry(input logic func, input worker_type worker,
                             input value_type value,
                             input logic last_worker, input logic last_task);
      gpta_pkg::req_type item;
      int                gap;
      item.func        = func;
      item.worker      = worker;
      item.value       = value;
      item.last_worker = last_worker;
      item.last_task   = last_task;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_worker      <= worker;
      req_value       <= value;
      req_last_worker <= last_worker;
      req_last_task   <= last_task;
      do @(posedge clock); while (req_stall);
      predict_assignment(item);
      items_sent++;
   endtask

   task automatic compare_field(input string name, input int unsigned expected,
                                input int unsigned actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pend_count == 0) begin
            $display("%0t: unexpected result transfer, expected none actual task %0d",
                     $time, rsp_task_index);
            errors++;
         end else begin
            want = decision_fifo[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            pend_count--;
            compare_field("task_index", 32'(want.task_index), 32'(rsp_task_index));
            compare_field("chosen_worker", 32'(want.chosen_worker),
                          32'(rsp_chosen_worker));
            compare_field("assigned", 32'(want.assigned), 32'(rsp_assigned));
            compare_field("gained", 32'(want.gained), 32'(rsp_gained));
            compare_field("job_done", 32'(want.job_done), 32'(rsp_job_done));
            compare_field("job_total", 32'(want.job_total), 32'(rsp_job_total));
         end
      end
   end

   // Result side back-pressure: a hold of random length, at times none, before each transfer.
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         n = draw_wait(rsp_quiet);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed_cases();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      // Capacity clamping, with end markers on a load that must be ignored.
      send_entry(gpta_pkg::FUNC_LOAD, 4'd0, 16'sh8000, 1'b1, 1'b1);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd1, 16'sd32767, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd2, 16'sd256, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd3, 16'sd255, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd4, -16'sd1, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd6, 16'sd1, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd15, 16'sd2, 1'b0, 1'b0);
      // No capacity, non-positive benefits, ties, a mid-task load and a stray
      // last_task without last_worker.
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd0, 16'sd32767, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd1, 16'sd0, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd2, 16'sh8000, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd3, 16'sd100, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd6, 16'sd100, 1'b0, 1'b1);
      send_entry(gpta_pkg::FUNC_LOAD, 4'd4, 16'sd3, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd4, 16'sd100, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd15, 16'sd32767, 1'b1, 1'b0);
      // Worker 15 runs out of capacity, so the job ends incomplete.
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd15, 16'sd9, 1'b1, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd15, 16'sd9, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd5, 16'sd7, 1'b1, 1'b1);
      // Single-task job that completes.
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd1, 16'sd32767, 1'b1, 1'b1);
      // Task where nobody qualifies, then a task won by worker 3 that ends the job incomplete.
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd14, -16'sd1, 1'b0, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd9, 16'sd50, 1'b1, 1'b0);
      send_entry(gpta_pkg::FUNC_BENEFIT, 4'd3, 16'sd1, 1'b1, 1'b1);
   endtask

   task automatic test_counter_saturation();
      int k;
      req_quiet = 1'b1;
      rsp_quiet = 1'b0;
      for (k = 0; k < gpta_pkg::MAX_WORKERS; k++)
         send_entry(gpta_pkg::FUNC_LOAD, worker_type'(k), 16'sd255, 1'b0, 1'b0);
      // More tasks than the counters hold: counts and total saturate, index wraps.
      for (k = 0; k < 520; k++)
         send_entry(gpta_pkg::FUNC_BENEFIT, worker_type'(k), 16'sd32767, 1'b1, k == 519);
   endtask

   function automatic value_type random_capacity();
      if ($urandom_range(0, 4) != 0) return value_type'($urandom_range(0, 3));
      return value_type'($urandom_range(0, 65535));
   endfunction

   function automatic value_type random_benefit();
      case ($urandom_range(0, 9))
         0: return value_type'($urandom_range(0, 65535));
         1: return value_type'(-int'($urandom_range(0, 5)));
         default: return value_type'($urandom_range(1, 20));
      endcase
   endfunction

   task automatic run_random_job();
      int  n_workers;
      int  n_tasks;
      int  t;
      int  k;
      int  w;
      bit  broken;
      bit  lw;
      n_workers = int'($urandom_range(1, gpta_pkg::MAX_WORKERS));
      n_tasks   = int'($urandom_range(1, 8));
      broken    = ($urandom_range(0, 9) == 0);
      for (k = 0; k < n_workers; k++)
         if ($urandom_range(0, 3) != 0)
            send_entry(gpta_pkg::FUNC_LOAD, worker_type'(k), random_capacity(),
                       $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
      for (t = 0; t < n_tasks; t++) begin
         for (k = 0; k < n_workers; k++) begin
            w  = ($urandom_range(0, 7) == 0) ?
                 int'($urandom_range(0, gpta_pkg::MAX_WORKERS - 1)) : k;
            lw = (k == n_workers - 1);
            if ($urandom_range(0, 19) == 0)
               send_entry(gpta_pkg::FUNC_LOAD,
                          worker_type'($urandom_range(0, gpta_pkg::MAX_WORKERS - 1)),
                          random_capacity(), 1'b0, 1'b0);
            send_entry(gpta_pkg::FUNC_BENEFIT, worker_type'(w), random_benefit(), lw,
                       (lw && t == n_tasks - 1) || (broken && $urandom_range(0, 3) == 0));
         end
         if (broken && $urandom_range(0, 5) == 0) return;
      end
   endtask

   task automatic test_random_jobs();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         req_quiet = ($urandom_range(0, 5) == 0);
         rsp_quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12))
               send_entry($urandom_range(0, 1) == 1,
                          worker_type'($urandom_range(0, gpta_pkg::MAX_WORKERS - 1)),
                          value_type'($urandom_range(0, 65535)),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
         end else begin
            run_random_job();
         end
      end
   endtask

   initial begin
      for (int i = 0; i < gpta_pkg::MAX_WORKERS; i++) cap_left[i] = '0;
      lead_valid     = 1'b0;
      lead_worker    = '0;
      lead_benefit   = '0;
      tasks_seen     = '0;
      tasks_assigned = '0;
      job_sum        = '0;
      wr_ptr         = '0;
      rd_ptr         = '0;
      pend_count     = 0;
      errors         = 0;
      items_sent     = 0;
      idle_cycles    = 0;
      req_quiet      = 1'b0;
      rsp_quiet      = 1'b0;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= 1'b0;
      req_worker      <= '0;
      req_value       <= '0;
      req_last_worker <= 1'b0;
      req_last_task   <= 1'b0;
      rsp_stall       <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_counter_saturation();
      test_random_jobs();

      req_valid <= 1'b0;
      while (pend_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
design/gpta_pkg.sv
design/gpta_core.sv
design/greedy_per_task_assignment.sv
verif/tb_greedy_per_task_assignment.sv
